// File: rtl/ttr_pkg.sv
// Package: shared codes and types for the timer table.
package ttr_pkg;
	typedef enum logic [2:0] {
		FN_ADD = 3'd0, FN_REMOVE = 3'd1, FN_SET_IVL = 3'd2, FN_SET_REP = 3'd3,
		FN_SET_DATA = 3'd4, FN_PULSE = 3'd5, FN_CLEAR = 3'd6, FN_NOP = 3'd7
	} func_t;
	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_BADID = 3'd1, ST_FULL = 3'd2, ST_FIRED = 3'd3,
		ST_NONE = 3'd4, ST_RSV5 = 3'd5, ST_RSV6 = 3'd6, ST_RSV7 = 3'd7
	} status_t;
	localparam int MAX_RESULTS = 16;

	// input beat
	typedef struct packed {
		func_t       func;
		logic [3:0]  timer_id;
		logic [31:0] interval;
		logic        repeat_req;
		logic [31:0] payload;
		logic        payload_present;
		logic        has_callback;
		logic [47:0] now;
	} op_beat_t;

	// result beat
	typedef struct packed {
		status_t     status;
		logic [3:0]  result_id;
		logic [31:0] fired_payload;
		logic        fired_payload_present;
		logic        last;
	} res_beat_t;
endpackage

// File: rtl/ttr_if.sv
// Interface: valid/ready channel with a generic payload.
interface ttr_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ttr_ram.sv
// Generic single-port-write, registered-read RAM.
module ttr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/timer_table_with_id_recycling.sv
// Top level: timer table with id recycling.
// Table of TIMERS software timers. Input beats carry one operation; each gives one
// result beat, a pulse gives one beat per fired timer (or one "nothing due" beat).
// Add, remove and set operations step through a memory read and a write back; the
// input then reopens once the result register is free.
// A pulse runs a release sweep over every entry, a due-check sweep that reads and
// then checks each entry, a step to send the final fired beat and a second release
// sweep. Each fired beat is held back until the next due entry is found, so the
// final one carries last; a stalled output holds the due-check sweep.
// Interval, deadline and payload sit in one RAM; flags, the free-id FIFO and the
// fresh-id counter are flip-flops. Clear-all and reset act at once; no clearing pass.
module timer_table_with_id_recycling #(
	parameter int TIMERS       = 16,
	parameter int TIME_BITS    = 48,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	ttr_if.sink  in_ch,
	ttr_if.source out_ch
);
	import ttr_pkg::*;

	localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int IW1 = IW + 1;
	localparam int CW = $clog2(TIMERS + 1);
	localparam int EW = 32 + TIME_BITS + PAYLOAD_BITS + 1;
	localparam int RW = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic [31:0]             ivl;
		logic [TIME_BITS-1:0]    dl;
		logic                    has;
		logic [PAYLOAD_BITS-1:0] pay;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE, S_OP_RD, S_OP_WR, S_REL, S_SCAN_RD, S_SCAN_CHK, S_OUT
	} state_t;

	// input beat fields
	logic [2:0]  f_func;
	logic [3:0]  f_id;
	logic [31:0] f_ivl;
	logic        f_rep, f_pres, f_cb;
	logic [31:0] f_pay;
	logic [47:0] f_now;
	assign f_func = in_ch.data.func;
	assign f_id   = in_ch.data.timer_id;
	assign f_ivl  = in_ch.data.interval;
	assign f_rep  = in_ch.data.repeat_req;
	assign f_pay  = in_ch.data.payload;
	assign f_pres = in_ch.data.payload_present;
	assign f_cb   = in_ch.data.has_callback;
	assign f_now  = in_ch.data.now;

	state_t state_q;
	logic [TIMERS-1:0] valid_q, pend_q, armed_q, rep_q;
	logic [IW-1:0] fifo_q [TIMERS];
	logic [IW-1:0] head_q;
	logic [CW-1:0] cnt_q, fresh_q;

	func_t                   op_q;
	logic [IW-1:0]           tid_q;
	logic                    idok_q;
	logic [31:0]             ivl_q;
	logic                    rep_in_q, cb_q;
	logic                    has_in_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [TIME_BITS-1:0]    now_q;
	logic [IW-1:0]           idx_q;
	logic                    wrap_q;
	logic [RW-1:0]           nres_q;

	// fired beat held back until the next one is found
	logic                    hold_q;
	logic [IW-1:0]           h_id_q;
	logic [31:0]             h_pay_q;
	logic                    h_has_q;

	logic                    o_valid_q;
	status_t                 o_st_q;
	logic [3:0]              o_id_q;
	logic [31:0]             o_pay_q;
	logic                    o_has_q, o_last_q;

	// entry RAM
	logic          we;
	logic [IW-1:0] waddr, raddr;
	entry_t        wdata, rdata;
	ttr_ram #(.WIDTH(EW), .DEPTH(TIMERS)) u_ram (
		.clk, .we, .waddr, .wdata(wdata), .raddr, .rdata(rdata)
	);

	// saturating deadline add
	function automatic logic [TIME_BITS-1:0] sat_add(
		input logic [TIME_BITS-1:0] t, input logic [31:0] iv);
		logic [TIME_BITS+32:0] s;
		begin
			s = {33'd0, t} + {{(TIME_BITS+1){1'b0}}, iv};
			sat_add = (s[TIME_BITS+32:TIME_BITS] != '0) ? '1 : s[TIME_BITS-1:0];
		end
	endfunction

	logic id_in_range;
	assign id_in_range = ({28'd0, f_id} < 32'(TIMERS));
	logic [IW-1:0] f_idx;
	assign f_idx = IW'(f_id);

	// FIFO write slot: head plus count, wrapped once
	logic [IW1-1:0] tail_sum;
	logic [IW-1:0]  tail;
	assign tail_sum = {1'b0, head_q} + IW1'(cnt_q);
	assign tail = (32'(tail_sum) >= TIMERS) ? IW'(32'(tail_sum) - TIMERS) : IW'(tail_sum);

	logic [IW-1:0] head_nxt;
	assign head_nxt = (32'(head_q) == TIMERS - 1) ? '0 : head_q + 1'b1;

	logic out_free;
	assign out_free = !o_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE) && out_free;

	logic due;
	assign due = valid_q[idx_q] && armed_q[idx_q] && (now_q >= rdata.dl)
		&& (32'(nres_q) < MAX_RESULTS);

	// a due entry is taken once the held beat can move on
	logic take;
	assign take = due && (!hold_q || out_free);

	logic last_idx;
	assign last_idx = (32'(idx_q) == TIMERS - 1);

	// result register loads a new beat
	logic o_load;
	assign o_load = (state_q == S_OP_WR)
		|| (state_q == S_REL && last_idx && wrap_q && nres_q == '0)
		|| (state_q == S_SCAN_CHK && take && hold_q)
		|| (state_q == S_OUT && hold_q && out_free);

	// RAM access control
	always_comb begin
		we    = 1'b0;
		waddr = tid_q;
		wdata = rdata;
		raddr = tid_q;
		case (state_q)
			S_OP_WR: begin
				if (op_q == FN_ADD) begin
					we = 1'b1;
					wdata.ivl = ivl_q;
					wdata.dl  = sat_add(now_q, ivl_q);
					wdata.has = has_in_q;
					wdata.pay = pay_q;
				end else if (idok_q && op_q == FN_SET_IVL) begin
					we = 1'b1;
					wdata.ivl = ivl_q;
					wdata.dl  = sat_add(now_q, ivl_q);
				end else if (idok_q && op_q == FN_SET_DATA) begin
					we = 1'b1;
					wdata.has = has_in_q;
					wdata.pay = pay_q;
				end
			end
			S_SCAN_RD:  raddr = idx_q;
			S_SCAN_CHK: begin
				raddr = idx_q;
				waddr = idx_q;
				if (take && rep_q[idx_q]) begin
					we = 1'b1;
					wdata.dl = sat_add(now_q, rdata.ivl);
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			pend_q    <= '0;
			armed_q   <= '0;
			rep_q     <= '0;
			fifo_q    <= '{default: '0};
			head_q    <= '0;
			cnt_q     <= '0;
			fresh_q   <= '0;
			o_valid_q <= 1'b0;
			o_st_q    <= ST_OK;
			o_id_q    <= '0;
			o_pay_q   <= '0;
			o_has_q   <= 1'b0;
			o_last_q  <= 1'b0;
			op_q      <= FN_NOP;
			tid_q     <= '0;
			idok_q    <= 1'b0;
			ivl_q     <= '0;
			rep_in_q  <= 1'b0;
			cb_q      <= 1'b0;
			has_in_q  <= 1'b0;
			pay_q     <= '0;
			now_q     <= '0;
			idx_q     <= '0;
			nres_q    <= '0;
			wrap_q    <= 1'b0;
			hold_q    <= 1'b0;
			h_id_q    <= '0;
			h_pay_q   <= '0;
			h_has_q   <= 1'b0;
		end else begin
			o_valid_q <= o_load || (o_valid_q && !out_ch.ready);
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						op_q     <= func_t'(f_func);
						tid_q    <= f_idx;
						idok_q   <= id_in_range && valid_q[f_idx] && !pend_q[f_idx];
						ivl_q    <= f_ivl;
						rep_in_q <= f_rep;
						cb_q     <= f_cb;
						has_in_q <= f_pres;
						pay_q    <= f_pres ? PAYLOAD_BITS'(f_pay) : '0;
						now_q    <= TIME_BITS'(f_now);
						idx_q    <= '0;
						nres_q   <= '0;
						wrap_q   <= 1'b0;
						if (func_t'(f_func) == FN_PULSE) state_q <= S_REL;
						else state_q <= S_OP_RD;
					end
				end
				S_OP_RD: begin
					state_q <= S_OP_WR;
					o_st_q  <= ST_OK;
					o_id_q  <= '0;
					o_pay_q <= '0;
					o_has_q <= 1'b0;
					o_last_q <= 1'b1;
					case (op_q)
						FN_ADD: begin
							if (cnt_q != '0) begin
								tid_q  <= fifo_q[head_q];
								head_q <= head_nxt;
								cnt_q  <= cnt_q - 1'b1;
							end else if (32'(fresh_q) < TIMERS) begin
								tid_q   <= IW'(fresh_q);
								fresh_q <= fresh_q + 1'b1;
							end else begin
								op_q   <= FN_NOP;
								o_st_q <= ST_FULL;
							end
						end
						FN_REMOVE, FN_SET_IVL, FN_SET_REP, FN_SET_DATA:
							if (!idok_q) o_st_q <= ST_BADID;
						FN_CLEAR: begin
							valid_q <= '0;
							pend_q  <= '0;
							armed_q <= '0;
							rep_q   <= '0;
							head_q  <= '0;
							cnt_q   <= '0;
							fresh_q <= '0;
						end
						default: ;
					endcase
				end
				S_OP_WR: begin
					if (op_q == FN_ADD) begin
						valid_q[tid_q] <= 1'b1;
						pend_q[tid_q]  <= 1'b0;
						armed_q[tid_q] <= cb_q;
						rep_q[tid_q]   <= rep_in_q;
						o_id_q         <= 4'(tid_q);
					end else if (idok_q && op_q == FN_REMOVE) begin
						pend_q[tid_q] <= 1'b1;
					end else if (idok_q && op_q == FN_SET_REP) begin
						rep_q[tid_q] <= rep_in_q;
					end
					state_q   <= S_IDLE;
				end
				S_REL: begin
					// one entry a cycle: free pending ids in ascending order
					if (pend_q[idx_q]) begin
						pend_q[idx_q] <= 1'b0;
						if (valid_q[idx_q]) begin
							valid_q[idx_q] <= 1'b0;
							armed_q[idx_q] <= 1'b0;
							rep_q[idx_q]   <= 1'b0;
							if (32'(cnt_q) < TIMERS) begin
								fifo_q[tail] <= idx_q;
								cnt_q <= cnt_q + 1'b1;
							end
						end
					end
					if (last_idx) begin
						idx_q <= '0;
						if (wrap_q) begin
							if (nres_q == '0) begin
								o_st_q   <= ST_NONE;
								o_id_q   <= '0;
								o_pay_q  <= '0;
								o_has_q  <= 1'b0;
								o_last_q <= 1'b1;
							end
							state_q <= S_IDLE;
						end else state_q <= S_SCAN_RD;
					end else idx_q <= idx_q + 1'b1;
				end
				S_SCAN_RD: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (take) begin
						// previous fired beat goes out, this one is held
						if (hold_q) begin
							o_st_q   <= ST_FIRED;
							o_id_q   <= 4'(h_id_q);
							o_pay_q  <= h_pay_q;
							o_has_q  <= h_has_q;
							o_last_q <= 1'b0;
						end
						hold_q  <= 1'b1;
						h_id_q  <= idx_q;
						h_pay_q <= rdata.has ? 32'(rdata.pay) : '0;
						h_has_q <= rdata.has;
						nres_q  <= nres_q + 1'b1;
						if (!rep_q[idx_q]) pend_q[idx_q] <= 1'b1;
						if (last_idx) begin
							idx_q <= '0; wrap_q <= 1'b1; state_q <= S_OUT;
						end else begin
							idx_q <= idx_q + 1'b1; state_q <= S_SCAN_RD;
						end
					end else if (!due) begin
						if (last_idx) begin
							idx_q <= '0; wrap_q <= 1'b1; state_q <= S_OUT;
						end else begin
							idx_q <= idx_q + 1'b1; state_q <= S_SCAN_RD;
						end
					end
				end
				S_OUT: begin
					// the held fired beat is the final one
					if (!hold_q) begin
						state_q <= S_REL;
					end else if (out_free) begin
						o_st_q   <= ST_FIRED;
						o_id_q   <= 4'(h_id_q);
						o_pay_q  <= h_pay_q;
						o_has_q  <= h_has_q;
						o_last_q <= 1'b1;
						hold_q   <= 1'b0;
						state_q  <= S_REL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid = o_valid_q;
	assign out_ch.data.status = o_st_q;
	assign out_ch.data.result_id = o_id_q;
	assign out_ch.data.fired_payload = o_pay_q;
	assign out_ch.data.fired_payload_present = o_has_q;
	assign out_ch.data.last = o_last_q;
endmodule
